[rtl/core/xysc_pkg.sv]
// Shared types and constants for the XMODEM/YMODEM sender control block.
package xysc_pkg;

   // Peer control bytes
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_CRQ = 8'h43;

   // Block sizes
   localparam logic [10:0] SHORT_BLOCK_BYTES = 11'd128;
   localparam logic [10:0] LONG_BLOCK_BYTES  = 11'd1024;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_PROTOCOL_MODE = 2'd0,
      REG_MAX_RETRIES   = 2'd1,
      REG_TIMEOUT_TICKS = 2'd2
   } reg_index_type;

   // Configuration reset values
   localparam logic        RESET_PROTOCOL_MODE = 1'b0;
   localparam logic [7:0]  RESET_MAX_RETRIES   = 8'd10;
   localparam logic [15:0] RESET_TIMEOUT_TICKS = 16'd10000;

   // Item operations
   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_BYTE   = 2'd1,
      OP_TICK   = 2'd2,
      OP_CANCEL = 2'd3
   } op_type;

   // Framing commands
   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_METADATA  = 3'd1,
      ACT_DATA      = 3'd2,
      ACT_EOT       = 3'd3,
      ACT_BATCH_END = 3'd4,
      ACT_RESEND    = 3'd5,
      ACT_CANCEL    = 3'd6
   } action_type;

   // Transfer events
   typedef enum logic [2:0] {
      EV_NONE          = 3'd0,
      EV_FINISHED      = 3'd1,
      EV_NO_RESPONSE   = 3'd2,
      EV_NOT_STARTED   = 3'd3,
      EV_REMOTE_CANCEL = 3'd4,
      EV_LOCAL_CANCEL  = 3'd5,
      EV_START_REFUSED = 3'd6
   } event_type;

   // Sender phases, one-hot
   typedef enum logic [8:0] {
      PH_IDLE     = 9'b0_0000_0001,
      PH_START    = 9'b0_0000_0010,
      PH_META_ACK = 9'b0_0000_0100,
      PH_META_REQ = 9'b0_0000_1000,
      PH_DATA_ACK = 9'b0_0001_0000,
      PH_EOT1     = 9'b0_0010_0000,
      PH_EOT2     = 9'b0_0100_0000,
      PH_NEXT_REQ = 9'b0_1000_0000,
      PH_BATCH    = 9'b1_0000_0000
   } phase_type;

   // One input beat
   typedef struct packed {
      op_type      operation;
      logic [7:0]  rx_byte;
      logic        file_present;
      logic [31:0] file_size;
   } item_type;

   // Sender state apart from the offset-wide counters
   typedef struct packed {
      phase_type   phase;
      logic        check_crc;
      logic [7:0]  retry_count;
      logic [7:0]  next_block;
      logic [10:0] last_payload;
      logic [7:0]  file_index;
      logic [7:0]  files_sent;
      logic [15:0] timer_count;
      logic        timer_running;
   } state_type;

   // One result beat
   typedef struct packed {
      action_type  action;
      logic [7:0]  block_number;
      logic        long_block;
      logic        crc_mode;
      logic [10:0] payload_bytes;
      logic [31:0] block_offset;
      logic [7:0]  current_file;
      event_type   event_res;
      logic        file_done;
      logic        passthrough;
      logic [7:0]  terminal_byte;
      logic        busy_res;
   } result_type;

endpackage

[rtl/core/xymodem_sender_control.sv]
// Top level of the XMODEM/YMODEM sender control block.
// Takes one item per clock (start, peer byte, tick or local cancel) while the result
// channel does not stall, and gives exactly one result beat per item, carrying the framing
// command, event and terminal byte. An accepted item is held in the input register, decided
// and loaded into the result register once that register is free, so its result then stands
// on the rsp_ ports. The sustained rate is one item per cycle while rsp_stall is low,
// set by the state update between the input and result registers; a stalled result holds
// the input register, which then stalls the input channel. Sizes and offsets are held at
// OFFSET_WIDTH bits. Configuration writes are taken in any cycle and should only be made
// while no item is in flight.
module xymodem_sender_control #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_file_present,
   input  logic [31:0] req_file_size,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [7:0]  rsp_block_number,
   output logic        rsp_long_block,
   output logic        rsp_crc_mode,
   output logic [10:0] rsp_payload_bytes,
   output logic [31:0] rsp_block_offset,
   output logic [7:0]  rsp_current_file,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_file_done,
   output logic        rsp_passthrough,
   output logic [7:0]  rsp_terminal_byte,
   output logic        rsp_busy_res,
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic                    protocol_mode_ff;
   logic [7:0]              max_retries_ff;
   logic [15:0]             timeout_ticks_ff;
   logic                    item_valid_ff;
   xysc_pkg::item_type      item_ff;
   xysc_pkg::item_type      item_in;
   xysc_pkg::state_type     state_ff;
   xysc_pkg::state_type     state_in;
   logic [OFFSET_WIDTH-1:0] size_ff;
   logic [OFFSET_WIDTH-1:0] size_in;
   logic [OFFSET_WIDTH-1:0] acked_ff;
   logic [OFFSET_WIDTH-1:0] acked_in;
   logic                    rsp_valid_ff;
   xysc_pkg::result_type    rsp_ff;
   xysc_pkg::result_type    rsp_in;
   logic                    advance;
   logic                    req_accept;

   // Handshake: the held item moves on whenever the result register is free
   assign advance    = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = item_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign item_in.operation    = xysc_pkg::op_type'(req_operation);
   assign item_in.rx_byte      = req_rx_byte;
   assign item_in.file_present = req_file_present;
   assign item_in.file_size    = req_file_size;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_mode_ff <= xysc_pkg::RESET_PROTOCOL_MODE;
         max_retries_ff   <= xysc_pkg::RESET_MAX_RETRIES;
         timeout_ticks_ff <= xysc_pkg::RESET_TIMEOUT_TICKS;
      end else if (csr_valid && csr_ready) begin
         case (xysc_pkg::reg_index_type'(csr_index))
            xysc_pkg::REG_PROTOCOL_MODE: protocol_mode_ff <= csr_wdata[0];
            xysc_pkg::REG_MAX_RETRIES:   max_retries_ff   <= csr_wdata[7:0];
            xysc_pkg::REG_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= req_accept || (item_valid_ff && !advance);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
   end

   // Per-item decision logic
   xysc_step #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_step (
      .protocol_mode (protocol_mode_ff),
      .max_retries   (max_retries_ff),
      .timeout_ticks (timeout_ticks_ff),
      .item          (item_ff),
      .st            (state_ff),
      .size_of_file  (size_ff),
      .acked_offset  (acked_ff),
      .st_in         (state_in),
      .size_in       (size_in),
      .acked_in      (acked_in),
      .res           (rsp_in)
   );

   // Sender state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= xysc_pkg::PH_IDLE;
         state_ff.check_crc     <= 1'b1;
         state_ff.retry_count   <= '0;
         state_ff.next_block    <= 8'd1;
         state_ff.last_payload  <= '0;
         state_ff.file_index    <= '0;
         state_ff.files_sent    <= '0;
         state_ff.timer_count   <= '0;
         state_ff.timer_running <= 1'b0;
         size_ff                <= '0;
         acked_ff               <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         size_ff  <= size_in;
         acked_ff <= acked_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_ff.action;
   assign rsp_block_number  = rsp_ff.block_number;
   assign rsp_long_block    = rsp_ff.long_block;
   assign rsp_crc_mode      = rsp_ff.crc_mode;
   assign rsp_payload_bytes = rsp_ff.payload_bytes;
   assign rsp_block_offset  = rsp_ff.block_offset;
   assign rsp_current_file  = rsp_ff.current_file;
   assign rsp_event_res     = rsp_ff.event_res;
   assign rsp_file_done     = rsp_ff.file_done;
   assign rsp_passthrough   = rsp_ff.passthrough;
   assign rsp_terminal_byte = rsp_ff.terminal_byte;
   assign rsp_busy_res      = rsp_ff.busy_res;

endmodule

[rtl/core/xysc_step.sv]
// Next-state and result logic for one sender item.
module xysc_step #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic                    protocol_mode,
   input  logic [7:0]              max_retries,
   input  logic [15:0]             timeout_ticks,
   input  xysc_pkg::item_type      item,
   input  xysc_pkg::state_type     st,
   input  logic [OFFSET_WIDTH-1:0] size_of_file,
   input  logic [OFFSET_WIDTH-1:0] acked_offset,
   output xysc_pkg::state_type     st_in,
   output logic [OFFSET_WIDTH-1:0] size_in,
   output logic [OFFSET_WIDTH-1:0] acked_in,
   output xysc_pkg::result_type    res
);

   // State after a transfer ends (check mode is kept)
   function automatic xysc_pkg::state_type idle_state(xysc_pkg::state_type s);
      xysc_pkg::state_type t;
      t               = s;
      t.phase         = xysc_pkg::PH_IDLE;
      t.retry_count   = '0;
      t.timer_running = 1'b0;
      t.timer_count   = '0;
      t.file_index    = '0;
      t.files_sent    = '0;
      t.last_payload  = '0;
      t.next_block    = 8'd1;
      return t;
   endfunction

   xysc_pkg::state_type     ns;
   xysc_pkg::result_type    r;
   logic [OFFSET_WIDTH-1:0] nsize;
   logic [OFFSET_WIDTH-1:0] nacked;
   logic [OFFSET_WIDTH-1:0] remain;
   logic [OFFSET_WIDTH-1:0] block_size;
   logic [16:0]             tick_sum;
   logic                    idle;
   logic                    ctrl_byte;
   logic                    f_retry;
   logic                    f_offer;
   logic                    f_send;
   logic [7:0]              v;

   always_comb begin
      ns        = st;
      nsize     = size_of_file;
      nacked    = acked_offset;
      r         = '0;
      r.current_file = st.file_index;
      f_retry   = 1'b0;
      f_offer   = 1'b0;
      f_send    = 1'b0;
      remain    = '0;
      block_size = protocol_mode ? OFFSET_WIDTH'(xysc_pkg::LONG_BLOCK_BYTES)
                                 : OFFSET_WIDTH'(xysc_pkg::SHORT_BLOCK_BYTES);
      v         = item.rx_byte;
      idle      = (st.phase == xysc_pkg::PH_IDLE);
      ctrl_byte = (v == xysc_pkg::BYTE_ACK) || (v == xysc_pkg::BYTE_NAK) ||
                  (v == xysc_pkg::BYTE_CRQ);
      tick_sum  = {1'b0, st.timer_count} + 17'd1;

      // Dispatch on the item
      case (item.operation)
         xysc_pkg::OP_START: begin
            if (!idle || !item.file_present) begin
               r.event_res = xysc_pkg::EV_START_REFUSED;
            end else begin
               ns               = idle_state(ns);
               nsize            = '0;
               nacked           = '0;
               ns.phase         = xysc_pkg::PH_START;
               ns.timer_running = 1'b1;
               ns.timer_count   = '0;
            end
         end
         xysc_pkg::OP_BYTE: begin
            if (idle || !(ctrl_byte || v == xysc_pkg::BYTE_CAN)) begin
               r.passthrough   = 1'b1;
               r.terminal_byte = v;
            end else if (v == xysc_pkg::BYTE_CAN) begin
               r.event_res = xysc_pkg::EV_REMOTE_CANCEL;
               ns          = idle_state(ns);
               nsize       = '0;
               nacked      = '0;
            end else begin
               // Protocol control byte in an active phase
               case (st.phase)
                  xysc_pkg::PH_START: begin
                     if (!protocol_mode &&
                         (v == xysc_pkg::BYTE_CRQ || v == xysc_pkg::BYTE_NAK)) begin
                        ns.check_crc     = (v == xysc_pkg::BYTE_CRQ);
                        ns.retry_count   = '0;
                        ns.timer_running = 1'b0;
                        f_offer          = 1'b1;
                     end else if (protocol_mode && v == xysc_pkg::BYTE_CRQ) begin
                        ns.check_crc     = 1'b1;
                        ns.retry_count   = '0;
                        ns.timer_running = 1'b0;
                        f_offer          = 1'b1;
                     end
                  end
                  xysc_pkg::PH_META_ACK: begin
                     if (v == xysc_pkg::BYTE_ACK) begin
                        ns.retry_count   = '0;
                        ns.phase         = xysc_pkg::PH_META_REQ;
                        ns.timer_running = 1'b1;
                        ns.timer_count   = '0;
                     end else if (v == xysc_pkg::BYTE_NAK) begin
                        f_retry = 1'b1;
                     end
                  end
                  xysc_pkg::PH_META_REQ: begin
                     if (v == xysc_pkg::BYTE_CRQ) begin
                        ns.retry_count   = '0;
                        ns.timer_running = 1'b0;
                        f_send           = 1'b1;
                     end else if (v == xysc_pkg::BYTE_NAK) begin
                        f_retry = 1'b1;
                     end
                  end
                  xysc_pkg::PH_DATA_ACK: begin
                     if (v == xysc_pkg::BYTE_ACK) begin
                        nacked = acked_offset + OFFSET_WIDTH'(st.last_payload);
                        ns.next_block    = st.next_block + 8'd1;
                        ns.retry_count   = '0;
                        ns.timer_running = 1'b0;
                        f_send           = 1'b1;
                     end else begin
                        f_retry = 1'b1;
                     end
                  end
                  xysc_pkg::PH_EOT1, xysc_pkg::PH_EOT2: begin
                     if (st.phase == xysc_pkg::PH_EOT1 && !protocol_mode) begin
                        if (v == xysc_pkg::BYTE_ACK) begin
                           // Single file done: transfer finished
                           r.file_done = 1'b1;
                           r.event_res = xysc_pkg::EV_FINISHED;
                           ns          = idle_state(ns);
                           nsize       = '0;
                           nacked      = '0;
                        end else if (v == xysc_pkg::BYTE_NAK) begin
                           f_retry = 1'b1;
                        end
                     end else if (st.phase == xysc_pkg::PH_EOT1 &&
                                  v == xysc_pkg::BYTE_NAK) begin
                        // First NAK of a batch EOT: send it again
                        r.action         = xysc_pkg::ACT_EOT;
                        ns.phase         = xysc_pkg::PH_EOT2;
                        ns.retry_count   = '0;
                        ns.timer_running = 1'b1;
                        ns.timer_count   = '0;
                     end else if (st.phase == xysc_pkg::PH_EOT2 &&
                                  v == xysc_pkg::BYTE_NAK) begin
                        f_retry = 1'b1;
                     end else begin
                        // EOT accepted: file done, wait for next request, or offer the next file on a C
                        r.file_done      = 1'b1;
                        ns.files_sent    = st.files_sent + 8'd1;
                        ns.file_index    = st.file_index + 8'd1;
                        nsize            = '0;
                        nacked           = '0;
                        ns.last_payload  = '0;
                        ns.phase         = xysc_pkg::PH_NEXT_REQ;
                        ns.retry_count   = '0;
                        ns.timer_running = 1'b1;
                        ns.timer_count   = '0;
                        f_offer          = (v == xysc_pkg::BYTE_CRQ);
                     end
                  end
                  xysc_pkg::PH_NEXT_REQ: begin
                     if (v == xysc_pkg::BYTE_CRQ) begin
                        ns.retry_count   = '0;
                        ns.timer_running = 1'b0;
                        f_offer          = 1'b1;
                     end
                  end
                  xysc_pkg::PH_BATCH: begin
                     if (v == xysc_pkg::BYTE_ACK) begin
                        r.event_res = xysc_pkg::EV_FINISHED;
                        ns          = idle_state(ns);
                        nsize       = '0;
                        nacked      = '0;
                     end else begin
                        f_retry = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         xysc_pkg::OP_TICK: begin
            if (!idle && st.timer_running) begin
               ns.timer_count = tick_sum[15:0];
               if (tick_sum >= {1'b0, timeout_ticks}) begin
                  ns.timer_count = '0;
                  if (st.phase == xysc_pkg::PH_START ||
                      st.phase == xysc_pkg::PH_NEXT_REQ) begin
                     if (st.retry_count >= max_retries) begin
                        r.action    = xysc_pkg::ACT_CANCEL;
                        r.event_res = xysc_pkg::EV_NOT_STARTED;
                        ns          = idle_state(ns);
                        nsize       = '0;
                        nacked      = '0;
                     end else begin
                        ns.retry_count   = st.retry_count + 8'd1;
                        ns.timer_running = 1'b1;
                        ns.timer_count   = '0;
                     end
                  end else begin
                     f_retry = 1'b1;
                  end
               end
            end
         end
         xysc_pkg::OP_CANCEL: begin
            if (!idle) begin
               r.action    = xysc_pkg::ACT_CANCEL;
               r.event_res = xysc_pkg::EV_LOCAL_CANCEL;
               ns          = idle_state(ns);
               nsize       = '0;
               nacked      = '0;
            end
         end
         default: begin
         end
      endcase

      // Resend the outstanding command or give up
      if (f_retry) begin
         if (ns.retry_count >= max_retries) begin
            r.action    = xysc_pkg::ACT_CANCEL;
            r.event_res = xysc_pkg::EV_NO_RESPONSE;
            ns          = idle_state(ns);
            nsize       = '0;
            nacked      = '0;
         end else begin
            ns.retry_count   = ns.retry_count + 8'd1;
            ns.timer_running = 1'b1;
            ns.timer_count   = '0;
            r.action         = xysc_pkg::ACT_RESEND;
            if (ns.phase == xysc_pkg::PH_DATA_ACK) begin
               r.block_number  = ns.next_block;
               r.long_block    = protocol_mode;
               r.crc_mode      = ns.check_crc;
               r.payload_bytes = ns.last_payload;
               r.block_offset  = 32'(nacked);
            end else if (ns.phase == xysc_pkg::PH_META_ACK ||
                         ns.phase == xysc_pkg::PH_META_REQ ||
                         ns.phase == xysc_pkg::PH_BATCH) begin
               r.crc_mode = 1'b1;
            end
         end
      end

      // Offer the file at the current index; with none present, end the batch or cancel
      if (f_offer) begin
         r.current_file = ns.file_index;
         if (!item.file_present) begin
            if (protocol_mode) begin
               r.action         = xysc_pkg::ACT_BATCH_END;
               r.crc_mode       = 1'b1;
               ns.phase         = xysc_pkg::PH_BATCH;
               ns.retry_count   = '0;
               ns.timer_running = 1'b1;
               ns.timer_count   = '0;
            end else begin
               r.action    = xysc_pkg::ACT_CANCEL;
               r.event_res = xysc_pkg::EV_START_REFUSED;
               ns          = idle_state(ns);
               nsize       = '0;
               nacked      = '0;
            end
         end else begin
            nsize           = OFFSET_WIDTH'(item.file_size);
            nacked          = '0;
            ns.last_payload = '0;
            ns.next_block   = 8'd1;
            if (protocol_mode) begin
               r.action         = xysc_pkg::ACT_METADATA;
               r.crc_mode       = 1'b1;
               ns.phase         = xysc_pkg::PH_META_ACK;
               ns.retry_count   = '0;
               ns.timer_running = 1'b1;
               ns.timer_count   = '0;
            end else begin
               f_send = 1'b1;
            end
         end
      end

      // Next data block, or EOT at end of file
      if (f_send) begin
         ns.retry_count   = '0;
         ns.timer_running = 1'b1;
         ns.timer_count   = '0;
         if (nacked >= nsize) begin
            r.action = xysc_pkg::ACT_EOT;
            ns.phase = xysc_pkg::PH_EOT1;
         end else begin
            remain          = nsize - nacked;
            ns.last_payload = (remain < block_size) ? 11'(remain) : 11'(block_size);
            r.action        = xysc_pkg::ACT_DATA;
            r.block_number  = ns.next_block;
            r.long_block    = protocol_mode;
            r.crc_mode      = ns.check_crc;
            r.payload_bytes = ns.last_payload;
            r.block_offset  = 32'(nacked);
            ns.phase        = xysc_pkg::PH_DATA_ACK;
         end
      end

      r.busy_res = (ns.phase != xysc_pkg::PH_IDLE);
   end

   assign st_in    = ns;
   assign size_in  = nsize;
   assign acked_in = nacked;
   assign res      = r;

endmodule
